FILE: src/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg: shared types and constants for the particle pool
// Operation codes, pool sizing and the word passed from front to back.
// ----------------------------------------------------------------------------
package ppu_pkg;
    localparam int PoolSize = 64;
    localparam int IdxW = (PoolSize > 1) ? $clog2(PoolSize) : 1;
    localparam logic [9:0] RotRate = 10'd655;
    localparam logic [16:0] OneQ16 = 17'h10000;

    typedef enum logic [1:0] {
        OP_SPAWN  = 2'd0,
        OP_TICK   = 2'd1,
        OP_RENDER = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] rot;
        logic [31:0] col_s;
        logic [31:0] col_e;
        logic [15:0] size_s;
        logic [15:0] size_e;
        logic [23:0] ld;
    } t_cmd;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SPAWN,
        BK_RD,
        BK_TK_MUL,
        BK_TK_WR,
        BK_RN_GO,
        BK_RN_DIV,
        BK_RN_MUL,
        BK_RN_ALPHA,
        BK_RN_OUT
    } t_bk_state;
endpackage

FILE: src/particle_pool_update.sv
// ----------------------------------------------------------------------------
// particle_pool_update: ring pool of particles with spawn, tick and render
// Top level: command queue in front, slot sweep engine behind it.
// ----------------------------------------------------------------------------
// Usage:
//   Present a word with start high; it is taken on an edge where busy is
//   low. Two commands may queue while the engine works.
//   Spawn fills the slot at the head index. Tick sweeps all 64 slots,
//   each through a read, a multiply and a write state. Render sweeps all
//   64 slots: per slot it reads the stores and loads the divider, runs the
//   40-step restoring divider of the fade factor, then two multiply stages
//   and an output state. The divider sets the render rate. The engine takes
//   the next command from the queue only once a sweep is over.
//   Each render result appears for one cycle with o_valid high; the receiver
//   cannot stall, so results are never held. o_last_of_run marks slot 63.
//   Reset clears the head index, live flags and the queue; stores are not
//   cleared, and a dead slot's stored values are output as zero.
//   Operation 3 is dropped at intake.
// ----------------------------------------------------------------------------
module particle_pool_update (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_vel_x,
    input  logic [31:0] i_vel_y,
    input  logic [31:0] i_start_rotation,
    input  logic [31:0] i_color_start,
    input  logic [31:0] i_color_end,
    input  logic [15:0] i_size_start,
    input  logic [15:0] i_size_end,
    input  logic [23:0] i_life_or_dt,
    output logic        o_valid,
    output logic        o_slot_live,
    output logic [31:0] o_out_pos_x,
    output logic [31:0] o_out_pos_y,
    output logic [31:0] o_out_rotation,
    output logic [15:0] o_out_size,
    output logic [31:0] o_out_color,
    output logic        o_last_of_run
);
    import ppu_pkg::*;

    t_cmd cmd, q_cmd;
    logic q_valid, q_pop;

    always_comb begin
        cmd.op = t_op'(i_operation);
        cmd.pos_x = i_pos_x;
        cmd.pos_y = i_pos_y;
        cmd.vel_x = i_vel_x;
        cmd.vel_y = i_vel_y;
        cmd.rot = i_start_rotation;
        cmd.col_s = i_color_start;
        cmd.col_e = i_color_end;
        cmd.size_s = i_size_start;
        cmd.size_e = i_size_end;
        cmd.ld = i_life_or_dt;
    end

    ppu_front u_front (.i_clk, .i_rst_n, .i_start(start), .i_cmd(cmd), .o_busy(busy),
        .o_q_valid(q_valid), .o_q_cmd(q_cmd), .i_q_pop(q_pop));

    ppu_back u_back (.i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_cmd(q_cmd),
        .o_q_pop(q_pop), .o_strobe(o_valid), .o_slot_live, .o_out_pos_x, .o_out_pos_y,
        .o_out_rotation, .o_out_size, .o_out_color, .o_last_of_run);
endmodule

FILE: src/ppu_ram.sv
// ----------------------------------------------------------------------------
// ppu_ram: generic single port RAM
// One address per cycle: its word is read and, with i_we, written; read data registered.
// ----------------------------------------------------------------------------
module ppu_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: src/ppu_front.sv
// ----------------------------------------------------------------------------
// ppu_front: command intake
// Accept words, drop unknown operations, and queue commands for the back end.
// ----------------------------------------------------------------------------
module ppu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ppu_pkg::t_cmd i_cmd,
    output logic          o_busy,
    output logic          o_q_valid,
    output ppu_pkg::t_cmd o_q_cmd,
    input  logic          i_q_pop
);
    import ppu_pkg::*;

    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push;

    assign o_busy = (r_cnt == 2'd2);
    assign push = i_start && !o_busy && (i_cmd.op != OP_NONE);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_q_pop |-> o_q_valid)
        else $error("pop of empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_q_pop) |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("push lost");
endmodule

FILE: src/ppu_div.sv
// ----------------------------------------------------------------------------
// ppu_div: radix-2 restoring divider for the fade factor
// Computes floor((rem << 16) / life), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [23:0] i_num,
    input  logic [23:0] i_den,
    output logic        o_done,
    output logic [39:0] o_quot
);
    logic [39:0] r_q;
    logic [24:0] r_r;
    logic [23:0] r_d;
    logic [5:0]  r_n;
    logic        r_run;
    logic [24:0] sh;
    logic        ge;

    assign sh = {r_r[23:0], r_q[39]};
    assign ge = (sh >= {1'b0, r_d});
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            o_done <= 1'b0;
            r_n <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_q <= {i_num, 16'd0};
                r_r <= '0;
                r_d <= i_den;
                r_n <= 6'd40;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_r <= ge ? sh - {1'b0, r_d} : sh;
                r_q <= {r_q[38:0], ge};
                r_n <= r_n - 6'd1;
                if (r_n == 6'd1) begin
                    r_run <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: src/ppu_back.sv
// ----------------------------------------------------------------------------
// ppu_back: pool state and slot sweep
// Execute spawn, tick and render commands over the slot stores.
// ----------------------------------------------------------------------------
module ppu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  ppu_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    output logic          o_strobe,
    output logic          o_slot_live,
    output logic [31:0]   o_out_pos_x,
    output logic [31:0]   o_out_pos_y,
    output logic [31:0]   o_out_rotation,
    output logic [15:0]   o_out_size,
    output logic [31:0]   o_out_color,
    output logic          o_last_of_run
);
    import ppu_pkg::*;

    t_bk_state r_st, n_st;
    t_cmd r_cmd;
    logic [IdxW-1:0] r_head, r_idx;
    logic [PoolSize-1:0] r_live;

    logic we;
    logic [63:0] pos_w, pos_r, vel_r, col_r;
    logic [31:0] rot_w, rot_r, siz_r;
    logic [23:0] lif_r;
    logic [24:0] rem_w, rem_r;

    logic [63:0] r_px, r_py;
    logic [24:0] r_rem;
    logic [16:0] r_t;
    logic signed [48:0] r_sz;
    logic [24:0] r_ch [4];
    logic [7:0] r_alpha;
    logic div_go, div_done;
    logic [39:0] div_q;
    logic last_slot;

    assign last_slot = (r_idx == IdxW'(PoolSize - 1));

    ppu_ram #(.Width(64), .Depth(PoolSize)) u_pos (.i_clk, .i_we(we), .i_addr(r_idx),
        .i_wdata(pos_w), .o_rdata(pos_r));
    ppu_ram #(.Width(64), .Depth(PoolSize)) u_vel (.i_clk, .i_we(we && r_st == BK_SPAWN),
        .i_addr(r_idx), .i_wdata({r_cmd.vel_x, r_cmd.vel_y}), .o_rdata(vel_r));
    ppu_ram #(.Width(32), .Depth(PoolSize)) u_rot (.i_clk, .i_we(we), .i_addr(r_idx),
        .i_wdata(rot_w), .o_rdata(rot_r));
    ppu_ram #(.Width(64), .Depth(PoolSize)) u_col (.i_clk, .i_we(we && r_st == BK_SPAWN),
        .i_addr(r_idx), .i_wdata({r_cmd.col_s, r_cmd.col_e}), .o_rdata(col_r));
    ppu_ram #(.Width(32), .Depth(PoolSize)) u_siz (.i_clk, .i_we(we && r_st == BK_SPAWN),
        .i_addr(r_idx), .i_wdata({r_cmd.size_s, r_cmd.size_e}), .o_rdata(siz_r));
    ppu_ram #(.Width(24), .Depth(PoolSize)) u_lif (.i_clk, .i_we(we && r_st == BK_SPAWN),
        .i_addr(r_idx), .i_wdata(r_cmd.ld), .o_rdata(lif_r));
    ppu_ram #(.Width(25), .Depth(PoolSize)) u_rem (.i_clk, .i_we(we), .i_addr(r_idx),
        .i_wdata(rem_w), .o_rdata(rem_r));

    ppu_div u_div (.i_clk, .i_rst_n, .i_go(div_go), .i_num(rem_r[23:0]),
        .i_den(lif_r), .o_done(div_done), .o_quot(div_q));

    logic signed [24:0] rem_sub;
    logic [31:0] rot_inc;
    logic [16:0] t_clamp;
    assign rem_sub = $signed(rem_r) - $signed({1'b0, r_cmd.ld});
    assign rot_inc = 32'(({10'd0, r_cmd.ld} * {24'd0, RotRate}) >> 16);
    assign t_clamp = (div_q > 40'(OneQ16)) ? OneQ16 : div_q[16:0];

    always_comb begin
        we = 1'b0;
        pos_w = {r_px[47:16], r_py[47:16]};
        rot_w = rot_r + rot_inc;
        rem_w = r_rem;
        if (r_st == BK_SPAWN) begin
            we = 1'b1;
            pos_w = {r_cmd.pos_x, r_cmd.pos_y};
            rot_w = r_cmd.rot;
            rem_w = {1'b0, r_cmd.ld};
        end else if (r_st == BK_TK_WR) begin
            we = 1'b1;
            pos_w = {pos_r[63:32] + r_px[47:16], pos_r[31:0] + r_py[47:16]};
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_st = (i_q_cmd.op == OP_SPAWN) ? BK_SPAWN : BK_RD;
                end
            end
            BK_SPAWN: n_st = BK_IDLE;
            BK_RD: begin
                if (r_cmd.op == OP_TICK) begin
                    n_st = BK_TK_MUL;
                end else begin
                    n_st = BK_RN_GO;
                end
            end
            BK_TK_MUL: n_st = BK_TK_WR;
            BK_TK_WR: n_st = last_slot ? BK_IDLE : BK_RD;
            BK_RN_GO: n_st = BK_RN_DIV;
            BK_RN_DIV: n_st = div_done ? BK_RN_MUL : BK_RN_DIV;
            BK_RN_MUL: n_st = BK_RN_ALPHA;
            BK_RN_ALPHA: n_st = BK_RN_OUT;
            BK_RN_OUT: n_st = last_slot ? BK_IDLE : BK_RD;
            default: n_st = BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = (r_st == BK_IDLE) && i_q_valid;
        div_go = (r_st == BK_RN_GO);
    end

    logic run_div;
    assign run_div = r_live[r_idx] && (lif_r != 24'd0) && !rem_r[24] && (rem_r != 25'd0);

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (r_st == BK_TK_MUL) begin
            r_rem <= rem_sub;
            r_px <= 64'($signed(vel_r[63:32])) * 64'($signed({1'b0, r_cmd.ld}));
            r_py <= 64'($signed(vel_r[31:0])) * 64'($signed({1'b0, r_cmd.ld}));
        end
        if (r_st == BK_RN_DIV && div_done) begin
            r_t <= run_div ? t_clamp : 17'd0;
        end
        if (r_st == BK_RN_MUL) begin
            r_sz <= $signed(siz_r[31:16]) * $signed({1'b0, r_t})
                  + $signed(siz_r[15:0]) * $signed({1'b0, 17'(OneQ16 - r_t)});
            for (int c = 0; c < 4; c++) begin
                r_ch[c] <= 25'(({17'd0, col_r[c*8 +: 8]} * (OneQ16 - r_t)
                    + {17'd0, col_r[32 + c*8 +: 8]} * r_t) >> 16);
            end
        end
        if (r_st == BK_RN_ALPHA) begin
            r_alpha <= 8'(({17'd0, r_ch[0][7:0]} * r_t) >> 16);
        end
        o_out_pos_x <= pos_r[63:32];
        o_out_pos_y <= pos_r[31:0];
        o_out_rotation <= rot_r;
        o_out_size <= r_sz[31:16];
        o_out_color <= {r_ch[3][7:0], r_ch[2][7:0], r_ch[1][7:0], r_alpha};
        o_slot_live <= r_live[r_idx];
        o_last_of_run <= last_slot;
        if (!r_live[r_idx]) begin
            o_out_pos_x <= '0;
            o_out_pos_y <= '0;
            o_out_rotation <= '0;
            o_out_size <= '0;
            o_out_color <= '0;
        end
        if (!i_rst_n) begin
            r_st <= BK_IDLE;
            r_head <= '0;
            r_idx <= '0;
            r_live <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_st <= n_st;
            o_strobe <= (r_st == BK_RN_OUT);
            if (r_st == BK_IDLE && o_q_pop) begin
                r_idx <= (i_q_cmd.op == OP_SPAWN) ? r_head : '0;
            end
            if (r_st == BK_SPAWN) begin
                r_live[r_idx] <= 1'b1;
                r_head <= (r_head == IdxW'(PoolSize - 1)) ? '0 : r_head + 1'b1;
            end
            if (r_st == BK_TK_MUL && r_live[r_idx] && ($signed(rem_sub) <= 0)) begin
                r_live[r_idx] <= 1'b0;
            end
            if (r_st == BK_TK_WR || r_st == BK_RN_OUT) begin
                r_idx <= last_slot ? '0 : r_idx + 1'b1;
            end
        end
    end

    // dead slots may take tick writes; a spawn rewrites every store before use
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_st) == BK_RN_OUT)
        else $error("strobe outside render");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == BK_SPAWN) |=> r_live[$past(r_idx)])
        else $error("spawned slot not live");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_st == BK_IDLE)
        else $error("pop while busy");
endmodule
